@@ hw/rtl/vmsa_pkg.sv @@
// shared constants, types and state encodings of the von mises stress aggregator
package vmsa_pkg;

   localparam int FRAC_BITS    = 16;
   localparam int MAX_EXPONENT = 16;

   localparam int STRESS_W = 32;
   localparam int NUM_COMP = 6;
   localparam int MAG_W    = STRESS_W + 1;
   localparam int SQ_W     = 2 * MAG_W;
   localparam int TOT_W    = 68;
   localparam int HALF_W   = TOT_W - 1;
   localparam int RAD_W    = 70;
   localparam int ROOT_W   = RAD_W / 2;
   localparam int SREM_W   = ROOT_W + 3;
   localparam int REF_W    = 32;
   localparam int DVD_W    = ROOT_W + FRAC_BITS;
   localparam int EXP_W    = 5;
   localparam int VAL_W    = 64;
   localparam int PROD_W   = 2 * VAL_W;
   localparam int HALF_MUL = VAL_W / 2;
   localparam int EQ_W     = 36;
   localparam int WGT_W    = 32;
   localparam int LAYOUT_W = 2;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 32;

   localparam logic [LAYOUT_W-1:0] LAYOUT_PLANE_STRESS = 2'd0;
   localparam logic [LAYOUT_W-1:0] LAYOUT_PLANE_STRAIN = 2'd1;
   localparam logic [LAYOUT_W-1:0] LAYOUT_SOLID        = 2'd2;

   localparam logic [CSR_IDX_W-1:0] CSR_LAYOUT   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REF      = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_EXPONENT = 2'd2;

   localparam logic [VAL_W-1:0] POS_LIMIT = {1'b0, {(VAL_W-1){1'b1}}};
   localparam logic [VAL_W-1:0] NEG_LIMIT = {1'b1, {(VAL_W-1){1'b0}}};

   typedef struct packed {
      logic [LAYOUT_W-1:0] layout;
      logic [REF_W-1:0]    ref_stress;
      logic [EXP_W-1:0]    exponent;
   } vmsa_cfg_type;

   typedef struct packed {
      logic [HALF_W-1:0] half_total;
      logic [WGT_W-1:0]  weight;
      logic              restart;
   } vmsa_work_type;

   typedef struct packed {
      logic push;
      logic pop;
   } vmsa_q_ctrl_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_SQ,
      F_PUSH
   } vmsa_front_state_type;

   typedef enum logic [3:0] {
      B_IDLE,
      B_SQRT,
      B_DIV,
      B_NORM,
      B_POW_SET,
      B_POW_MUL,
      B_POW_CHK,
      B_WGT_SET,
      B_WGT_MUL,
      B_WGT_CHK,
      B_ACC
   } vmsa_back_state_type;

endpackage

@@ hw/rtl/von_mises_stress_aggregator_unit.sv @@
// top level: configuration registers, front part, queue and back part
// the back part takes the next point from the queue only once it is idle again, so it sets the throughput
// square root takes 35 steps and the divide 51 steps, one bit each; each multiply sums four partial products
// the front accepts the next point while the back works, up to two points queued
// reset is synchronous: clears control, the running sum and loads register defaults
module von_mises_stress_aggregator_unit
   import vmsa_pkg::*;
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [223:0]           req_tdata,  // stress_0..stress_5, weight
   input  logic [0:0]             req_tuser,  // restart
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [167:0]           rsp_tdata,  // equivalent_stress, point_value, running_sum
   output logic [0:0]             rsp_tuser,  // saturated
   input  logic                   csr_wen,
   input  logic [CSR_IDX_W-1:0]   csr_index,
   input  logic [CSR_DAT_W-1:0]   csr_wdata
);

   logic [LAYOUT_W-1:0] layout_ff;
   logic [REF_W-1:0]    ref_ff;
   logic [EXP_W-1:0]    exp_ff;
   vmsa_cfg_type        cfg;
   vmsa_q_ctrl_type     q_ctrl;
   vmsa_work_type       wr_work, rd_work;
   logic                q_full, q_empty;
   logic [NUM_COMP-1:0][STRESS_W-1:0] stress;
   logic [EQ_W-1:0]     eq_stress;
   logic [VAL_W-1:0]    pv, rsum;
   logic                sat;

   always_ff @(posedge clock) begin
      if (reset) begin
         layout_ff <= LAYOUT_SOLID;
         ref_ff    <= REF_W'(1) << FRAC_BITS;
         exp_ff    <= EXP_W'(1);
      end else if (csr_wen) begin
         case (csr_index)
            CSR_LAYOUT:   layout_ff <= csr_wdata[LAYOUT_W-1:0];
            CSR_REF:      ref_ff    <= csr_wdata[REF_W-1:0];
            CSR_EXPONENT: exp_ff    <= csr_wdata[EXP_W-1:0];
            default: ;
         endcase
      end
   end

   assign cfg.layout     = layout_ff;
   assign cfg.ref_stress = ref_ff;
   assign cfg.exponent   = exp_ff;

   assign stress = req_tdata[NUM_COMP*STRESS_W-1:0];

   vmsa_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stress     (stress),
      .weight     (req_tdata[NUM_COMP*STRESS_W +: WGT_W]),
      .restart    (req_tuser[0]),
      .layout     (layout_ff),
      .q_full     (q_full),
      .q_push     (q_ctrl.push),
      .work       (wr_work)
   );

   vmsa_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (q_ctrl),
      .wr_data (wr_work),
      .rd_data (rd_work),
      .full    (q_full),
      .empty   (q_empty)
   );

   vmsa_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .q_empty           (q_empty),
      .q_data            (rd_work),
      .q_pop             (q_ctrl.pop),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .equivalent_stress (eq_stress),
      .point_value       (pv),
      .running_sum       (rsum),
      .saturated         (sat)
   );

   assign rsp_tdata = {4'b0, rsum, pv, eq_stress};
   assign rsp_tuser = sat;

endmodule

@@ hw/rtl/vmsa_front.sv @@
// front part: accepts a point, squares the stress differences and forms (N + 6T) / 2
module vmsa_front
   import vmsa_pkg::*;
(
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [NUM_COMP-1:0][STRESS_W-1:0]   stress,
   input  logic [WGT_W-1:0]                    weight,
   input  logic                                restart,
   input  logic [LAYOUT_W-1:0]                 layout,
   input  logic                                q_full,
   output logic                                q_push,
   output vmsa_work_type                       work
);

   vmsa_front_state_type state_ff, state_in;
   logic [NUM_COMP-1:0][MAG_W-1:0] mag_ff, mag_in;
   logic [SQ_W-1:0]   sq_ff, sq_in;
   logic [TOT_W-1:0]  acc_ff, acc_in;
   logic [2:0]        cnt_ff, cnt_in;
   logic [WGT_W-1:0]  weight_ff, weight_in;
   logic              restart_ff, restart_in;
   logic              accept;
   logic [TOT_W-1:0]  sq_ext;
   logic [TOT_W-1:0]  sq_add;

   function automatic logic [MAG_W-1:0] abs_diff(input logic [STRESS_W-1:0] a,
                                                 input logic [STRESS_W-1:0] b);
      logic [MAG_W-1:0] d;
      d = {a[STRESS_W-1], a} - {b[STRESS_W-1], b};
      return d[MAG_W-1] ? (~d + MAG_W'(1)) : d;
   endfunction

   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         F_IDLE: if (req_tvalid) state_in = F_SQ;
         F_SQ:   if (cnt_ff == 3'd6) state_in = F_PUSH;
         F_PUSH: if (!q_full) state_in = F_IDLE;
         default: state_in = F_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      q_push     = 1'b0;
      case (state_ff)
         F_IDLE:  req_tready = 1'b1;
         F_PUSH:  q_push = !q_full;
         default: ;
      endcase
   end

   // squares of entries 3..5 are shears and count six times
   assign sq_ext = TOT_W'(sq_ff);
   assign sq_add = (cnt_ff >= 3'd4) ? ((sq_ext << 2) + (sq_ext << 1)) : sq_ext;

   always_comb begin
      mag_in     = mag_ff;
      sq_in      = sq_ff;
      acc_in     = acc_ff;
      cnt_in     = cnt_ff;
      weight_in  = weight_ff;
      restart_in = restart_ff;
      if (accept) begin
         weight_in  = weight;
         restart_in = restart;
         cnt_in     = 3'd0;
         acc_in     = '0;
         case (layout)
            LAYOUT_PLANE_STRESS: begin
               mag_in[0] = abs_diff(stress[0], stress[1]);
               mag_in[1] = abs_diff(stress[1], '0);
               mag_in[2] = abs_diff(stress[0], '0);
               mag_in[3] = abs_diff(stress[2], '0);
               mag_in[4] = '0;
               mag_in[5] = '0;
            end
            LAYOUT_PLANE_STRAIN: begin
               mag_in[0] = abs_diff(stress[0], stress[1]);
               mag_in[1] = abs_diff(stress[1], stress[2]);
               mag_in[2] = abs_diff(stress[2], stress[0]);
               mag_in[3] = abs_diff(stress[3], '0);
               mag_in[4] = '0;
               mag_in[5] = '0;
            end
            default: begin
               mag_in[0] = abs_diff(stress[0], stress[1]);
               mag_in[1] = abs_diff(stress[1], stress[2]);
               mag_in[2] = abs_diff(stress[2], stress[0]);
               mag_in[3] = abs_diff(stress[3], '0);
               mag_in[4] = abs_diff(stress[4], '0);
               mag_in[5] = abs_diff(stress[5], '0);
            end
         endcase
      end else if (state_ff == F_SQ) begin
         if (cnt_ff != 3'd6) begin
            sq_in = mag_ff[0] * mag_ff[0];
            for (int i = 0; i < NUM_COMP - 1; i++) begin
               mag_in[i] = mag_ff[i+1];
            end
            mag_in[NUM_COMP-1] = '0;
         end
         if (cnt_ff != 3'd0) acc_in = acc_ff + sq_add;
         cnt_in = cnt_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      mag_ff     <= mag_in;
      sq_ff      <= sq_in;
      acc_ff     <= acc_in;
      cnt_ff     <= cnt_in;
      weight_ff  <= weight_in;
      restart_ff <= restart_in;
   end

   assign work.half_total = acc_ff[TOT_W-1:1];
   assign work.weight     = weight_ff;
   assign work.restart    = restart_ff;

endmodule

@@ hw/rtl/vmsa_queue.sv @@
// two-entry queue between front and back parts
module vmsa_queue
   import vmsa_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  vmsa_q_ctrl_type ctrl,
   input  vmsa_work_type   wr_data,
   output vmsa_work_type   rd_data,
   output logic            full,
   output logic            empty
);

   vmsa_work_type mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ ctrl.push;
      rd_ptr_in = rd_ptr_ff ^ ctrl.pop;
      cnt_in    = cnt_ff + 2'(ctrl.push) - 2'(ctrl.pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff    <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
      if (ctrl.push) mem_ff[wr_ptr_ff] <= wr_data;
   end

`ifndef NO_ASSERTIONS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.push && full)) else $error("push into full queue");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      !(ctrl.pop && empty)) else $error("pop from empty queue");
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff != 2'd3) else $error("queue count out of range");
   a_ptr_track: assert property (@(posedge clock) disable iff (reset)
      (cnt_ff == 2'd0 || cnt_ff == 2'd2) |-> (wr_ptr_ff == rd_ptr_ff))
      else $error("queue pointers disagree with count");
`endif

endmodule

@@ hw/rtl/vmsa_back.sv @@
// back part: square root, normalizing divide, power, weighting and the running sum
module vmsa_back
   import vmsa_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  vmsa_cfg_type         cfg,
   input  logic                 q_empty,
   input  vmsa_work_type        q_data,
   output logic                 q_pop,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [EQ_W-1:0]      equivalent_stress,
   output logic [VAL_W-1:0]     point_value,
   output logic [VAL_W-1:0]     running_sum,
   output logic                 saturated
);

   localparam logic [DVD_W-1:0] ONE_Q = DVD_W'(1) << FRAC_BITS;
   localparam logic [VAL_W-1:0] ONE_P = VAL_W'(1) << FRAC_BITS;
   localparam logic [EXP_W-1:0] EXP_CAP = EXP_W'(MAX_EXPONENT);

   vmsa_back_state_type state_ff, state_in;
   vmsa_work_type       item_ff, item_in;
   logic [RAD_W-1:0]    rad_ff, rad_in;
   logic [SREM_W-1:0]   srem_ff, srem_in;
   logic [ROOT_W-1:0]   root_ff, root_in;
   logic [5:0]          cnt_ff, cnt_in;
   logic [DVD_W-1:0]    dvd_ff, dvd_in;
   logic [REF_W-1:0]    drem_ff, drem_in;
   logic [DVD_W-1:0]    xmag_ff, xmag_in;
   logic                neg_ff, neg_in;
   logic [EXP_W-1:0]    exp_ff, exp_in;
   logic [EXP_W-1:0]    pcnt_ff, pcnt_in;
   logic [VAL_W-1:0]    pm_ff, pm_in;
   logic [VAL_W-1:0]    pv_ff, pv_in;
   logic                pvneg_ff, pvneg_in;
   logic [VAL_W-1:0]    term_ff, term_in;
   logic                sat_ff, sat_in;
   logic [VAL_W-1:0]    accum_ff, accum_in;
   logic [VAL_W-1:0]    ma_ff, ma_in;
   logic [VAL_W-1:0]    mb_ff, mb_in;
   logic [2:0]          mcnt_ff, mcnt_in;
   logic [VAL_W-1:0]    pp_ff, pp_in;
   logic [1:0]          psh_ff, psh_in;
   logic [PROD_W-1:0]   macc_ff, macc_in;
   logic                rv_ff, rv_in;
   logic [EQ_W-1:0]     req_ff, req_in;
   logic [VAL_W-1:0]    rpv_ff, rpv_in;
   logic [VAL_W-1:0]    rsum_ff, rsum_in;
   logic                rsat_ff, rsat_in;

   logic out_free;
   logic load_out;
   logic mul_active;

   logic [SREM_W-1:0]    s_part, s_trial;
   logic [REF_W:0]       d_part, d_ref, d_diff;
   logic                 d_bit;
   logic                 below;
   logic [EXP_W-1:0]     exp_cap;
   logic [HALF_MUL-1:0]  a_part, b_part;
   logic [PROD_W-1:0]    pp_shift;
   logic [PROD_W-FRAC_BITS-VAL_W-1:0] prod_hi;
   logic [VAL_W-1:0]     prod_lo;
   logic [VAL_W-1:0]     lim_pow, lim_wgt;
   logic                 over;
   logic [VAL_W-1:0]     pv_calc, base, sum;

   assign out_free   = !rv_ff || rsp_tready;
   assign mul_active = (state_ff == B_POW_MUL) || (state_ff == B_WGT_MUL);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE:    if (!q_empty) state_in = B_SQRT;
         B_SQRT:    if (cnt_ff == 6'(ROOT_W - 1)) state_in = B_DIV;
         B_DIV:     if (cnt_ff == 6'(DVD_W - 1)) state_in = B_NORM;
         B_NORM:    state_in = B_POW_SET;
         B_POW_SET: state_in = (pcnt_ff == exp_ff) ? B_WGT_SET : B_POW_MUL;
         B_POW_MUL: if (mcnt_ff == 3'd4) state_in = B_POW_CHK;
         B_POW_CHK: state_in = over ? B_WGT_SET : B_POW_SET;
         B_WGT_SET: state_in = B_WGT_MUL;
         B_WGT_MUL: if (mcnt_ff == 3'd4) state_in = B_WGT_CHK;
         B_WGT_CHK: state_in = B_ACC;
         B_ACC:     if (out_free) state_in = B_IDLE;
         default:   state_in = B_IDLE;
      endcase
   end

   always_comb begin
      q_pop    = 1'b0;
      load_out = 1'b0;
      case (state_ff)
         B_IDLE:  q_pop = !q_empty;
         B_ACC:   load_out = out_free;
         default: ;
      endcase
   end

   // restoring square root, two radicand bits a step
   assign s_part  = {srem_ff[SREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
   assign s_trial = {1'b0, root_ff, 2'b01};

   // restoring divide, one quotient bit a step; a zero reference counts as one
   assign d_ref  = (cfg.ref_stress == '0) ? (REF_W+1)'(1) : {1'b0, cfg.ref_stress};
   assign d_part = {drem_ff, dvd_ff[DVD_W-1]};
   assign d_diff = d_part - d_ref;
   assign d_bit  = (d_part >= d_ref);

   assign below   = (dvd_ff < ONE_Q);
   assign exp_cap = (cfg.exponent > EXP_CAP) ? EXP_CAP : cfg.exponent;

   // 64x64 product from four 32x32 partial products
   assign a_part = mcnt_ff[1] ? ma_ff[VAL_W-1:HALF_MUL] : ma_ff[HALF_MUL-1:0];
   assign b_part = mcnt_ff[0] ? mb_ff[VAL_W-1:HALF_MUL] : mb_ff[HALF_MUL-1:0];

   always_comb begin
      case (psh_ff)
         2'd0:    pp_shift = PROD_W'(pp_ff);
         2'd1:    pp_shift = PROD_W'(pp_ff) << HALF_MUL;
         default: pp_shift = PROD_W'(pp_ff) << VAL_W;
      endcase
   end

   assign prod_hi = macc_ff[PROD_W-1:FRAC_BITS+VAL_W];
   assign prod_lo = macc_ff[FRAC_BITS+VAL_W-1:FRAC_BITS];
   assign lim_pow = neg_ff ? NEG_LIMIT : POS_LIMIT;
   assign lim_wgt = pvneg_ff ? NEG_LIMIT : POS_LIMIT;
   assign over    = (prod_hi != '0) ||
                    (prod_lo > ((state_ff == B_WGT_CHK) ? lim_wgt : lim_pow));

   assign pv_calc = neg_ff ? (~pm_ff + VAL_W'(1)) : pm_ff;
   assign base    = item_ff.restart ? '0 : accum_ff;
   assign sum     = base + term_ff;

   always_comb begin
      item_in  = item_ff;
      rad_in   = rad_ff;
      srem_in  = srem_ff;
      root_in  = root_ff;
      cnt_in   = cnt_ff;
      dvd_in   = dvd_ff;
      drem_in  = drem_ff;
      xmag_in  = xmag_ff;
      neg_in   = neg_ff;
      exp_in   = exp_ff;
      pcnt_in  = pcnt_ff;
      pm_in    = pm_ff;
      pv_in    = pv_ff;
      pvneg_in = pvneg_ff;
      term_in  = term_ff;
      sat_in   = sat_ff;
      accum_in = accum_ff;
      ma_in    = ma_ff;
      mb_in    = mb_ff;
      mcnt_in  = mcnt_ff;
      pp_in    = pp_ff;
      psh_in   = psh_ff;
      macc_in  = macc_ff;
      rv_in    = rv_ff && !rsp_tready;
      req_in   = req_ff;
      rpv_in   = rpv_ff;
      rsum_in  = rsum_ff;
      rsat_in  = rsat_ff;

      if (mul_active) begin
         if (mcnt_ff != 3'd4) begin
            pp_in  = a_part * b_part;
            psh_in = 2'(mcnt_ff[1]) + 2'(mcnt_ff[0]);
         end
         if (mcnt_ff != 3'd0) macc_in = macc_ff + pp_shift;
         mcnt_in = mcnt_ff + 3'd1;
      end

      case (state_ff)
         B_IDLE: begin
            if (!q_empty) begin
               item_in = q_data;
               rad_in  = RAD_W'(q_data.half_total);
               srem_in = '0;
               root_in = '0;
               cnt_in  = '0;
            end
         end
         B_SQRT: begin
            rad_in = rad_ff << 2;
            if (s_part >= s_trial) begin
               srem_in = s_part - s_trial;
               root_in = {root_ff[ROOT_W-2:0], 1'b1};
            end else begin
               srem_in = s_part;
               root_in = {root_ff[ROOT_W-2:0], 1'b0};
            end
            cnt_in  = cnt_ff + 6'd1;
            dvd_in  = {root_in, {FRAC_BITS{1'b0}}};
            drem_in = '0;
            if (cnt_ff == 6'(ROOT_W - 1)) cnt_in = '0;
         end
         B_DIV: begin
            drem_in = d_bit ? d_diff[REF_W-1:0] : d_part[REF_W-1:0];
            dvd_in  = {dvd_ff[DVD_W-2:0], d_bit};
            cnt_in  = cnt_ff + 6'd1;
         end
         B_NORM: begin
            xmag_in = below ? (ONE_Q - dvd_ff) : (dvd_ff - ONE_Q);
            neg_in  = below && exp_cap[0];
            exp_in  = exp_cap;
            pcnt_in = '0;
            pm_in   = ONE_P;
            sat_in  = 1'b0;
         end
         B_POW_SET: begin
            ma_in   = pm_ff;
            mb_in   = VAL_W'(xmag_ff);
            mcnt_in = '0;
            macc_in = '0;
         end
         B_POW_CHK: begin
            if (over) begin
               pm_in  = lim_pow;
               sat_in = 1'b1;
            end else begin
               pm_in   = prod_lo;
               pcnt_in = pcnt_ff + EXP_W'(1);
            end
         end
         B_WGT_SET: begin
            pv_in    = pv_calc;
            pvneg_in = pv_calc[VAL_W-1];
            ma_in    = pv_calc[VAL_W-1] ? (~pv_calc + VAL_W'(1)) : pv_calc;
            mb_in    = VAL_W'(item_ff.weight);
            mcnt_in  = '0;
            macc_in  = '0;
         end
         B_WGT_CHK: begin
            if (over) begin
               term_in = pvneg_ff ? NEG_LIMIT : POS_LIMIT;
               sat_in  = 1'b1;
            end else begin
               term_in = pvneg_ff ? (~prod_lo + VAL_W'(1)) : prod_lo;
            end
         end
         B_ACC: begin
            if (load_out) begin
               rv_in   = 1'b1;
               req_in  = EQ_W'(root_ff);
               rpv_in  = pv_ff;
               // same-sign operands whose sum flips sign overflowed
               if ((base[VAL_W-1] == term_ff[VAL_W-1]) &&
                   (sum[VAL_W-1] != base[VAL_W-1])) begin
                  accum_in = base[VAL_W-1] ? NEG_LIMIT : POS_LIMIT;
                  rsat_in  = 1'b1;
               end else begin
                  accum_in = sum;
                  rsat_in  = sat_ff;
               end
               rsum_in = accum_in;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         accum_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         accum_ff <= accum_in;
         rv_ff    <= rv_in;
      end
      item_ff  <= item_in;
      rad_ff   <= rad_in;
      srem_ff  <= srem_in;
      root_ff  <= root_in;
      cnt_ff   <= cnt_in;
      dvd_ff   <= dvd_in;
      drem_ff  <= drem_in;
      xmag_ff  <= xmag_in;
      neg_ff   <= neg_in;
      exp_ff   <= exp_in;
      pcnt_ff  <= pcnt_in;
      pm_ff    <= pm_in;
      pv_ff    <= pv_in;
      pvneg_ff <= pvneg_in;
      term_ff  <= term_in;
      sat_ff   <= sat_in;
      ma_ff    <= ma_in;
      mb_ff    <= mb_in;
      mcnt_ff  <= mcnt_in;
      pp_ff    <= pp_in;
      psh_ff   <= psh_in;
      macc_ff  <= macc_in;
      req_ff   <= req_in;
      rpv_ff   <= rpv_in;
      rsum_ff  <= rsum_in;
      rsat_ff  <= rsat_in;
   end

   assign rsp_tvalid        = rv_ff;
   assign equivalent_stress = req_ff;
   assign point_value       = rpv_ff;
   assign running_sum       = rsum_ff;
   assign saturated         = rsat_ff;

`ifndef NO_ASSERTIONS
   a_pow_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_POW_SET) |-> (pcnt_ff <= exp_ff))
      else $error("power loop ran past exponent");
   a_mul_count: assert property (@(posedge clock) disable iff (reset)
      mul_active |-> (mcnt_ff <= 3'd4)) else $error("multiply step out of range");
   a_pop_only_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (state_ff == B_IDLE)) else $error("pop while busy");
`endif

endmodule

@@ verif/von_mises_stress_aggregator_unit_test.sv @@
// testbench for the von mises stress aggregator: random and directed points checked against a predictor
module von_mises_stress_aggregator_unit_test;
   import vmsa_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct {
      logic [5:0][31:0] stress;
      logic [31:0]      weight;
      logic             restart;
   } point_type;

   typedef struct {
      logic [35:0] equiv;
      logic [63:0] point_value;
      logic [63:0] running_sum;
      logic        saturated;
   } result_type;

   localparam longint unsigned CYCLE_LIMIT = 2_000_000;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [223:0]         req_tdata = '0;   // stress_0..stress_5, weight
   logic [0:0]           req_tuser = '0;   // restart
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [167:0]         rsp_tdata;        // equivalent_stress, point_value, running_sum
   logic [0:0]           rsp_tuser;        // saturated
   logic                 csr_wen = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DAT_W-1:0] csr_wdata = '0;

   von_mises_stress_aggregator_unit dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // predictor state
   logic [1:0]  cfg_layout = LAYOUT_SOLID;
   logic [31:0] cfg_ref = 32'd65536;
   logic [4:0]  cfg_exp = 5'd1;
   logic [63:0] sum_state = '0;

   point_type  pending_points[$];
   result_type expected_results[$];
   int         fails = 0;
   int         accepted = 0;
   int         idle_mode = 0;
   longint unsigned cycles = 0;

   function automatic logic [127:0] sq_diff(longint a, longint b);
      longint d;
      logic [63:0] m;
      d = a - b;
      m = d < 0 ? -d : d;
      return 128'(m) * 128'(m);
   endfunction

   function automatic logic [63:0] sq_mag(longint a);
      logic [63:0] m;
      m = a < 0 ? -a : a;
      return m * m;
   endfunction

   function automatic result_type eval_point(point_type p);
      longint      sv[6];
      logic [127:0] normal, total, prod;
      logic [63:0] shear, vm, t, rdiv, q, mag, pm, limit, pv, wmag, term, base, sum;
      longint      x;
      int          e;
      bit          neg, pv_neg, sat;
      result_type  r;
      sat = 0;
      for (int i = 0; i < 6; i++) sv[i] = longint'($signed(p.stress[i]));
      if (cfg_layout == LAYOUT_PLANE_STRESS) begin
         // out-of-plane normal is zero
         normal = sq_diff(sv[0], sv[1]) + sq_diff(sv[1], 0) + sq_diff(0, sv[0]);
         shear = sq_mag(sv[2]);
      end else begin
         normal = sq_diff(sv[0], sv[1]) + sq_diff(sv[1], sv[2]) + sq_diff(sv[2], sv[0]);
         shear = sq_mag(sv[3]);
         if (cfg_layout != LAYOUT_PLANE_STRAIN) shear += sq_mag(sv[4]) + sq_mag(sv[5]);
      end
      total = (normal + 128'(shear) * 128'd6) >> 1;
      vm = '0;
      for (int b = 34; b >= 0; b--) begin
         t = vm | (64'd1 << b);
         if (128'(t) * 128'(t) <= total) vm = t;
      end
      rdiv = cfg_ref == 0 ? 64'd1 : 64'(cfg_ref);
      q = (vm << FRAC_BITS) / rdiv;
      x = longint'(q) - (longint'(1) << FRAC_BITS);
      e = cfg_exp > MAX_EXPONENT ? MAX_EXPONENT : cfg_exp;
      mag = x < 0 ? -x : x;
      neg = x < 0 && e[0];
      limit = neg ? NEG_LIMIT : POS_LIMIT;
      pm = 64'd1 << FRAC_BITS;
      for (int i = 0; i < e; i++) begin
         prod = (128'(pm) * 128'(mag)) >> FRAC_BITS;
         if (prod > 128'(limit)) begin
            pm = limit;
            sat = 1;
            break;
         end
         pm = prod[63:0];
      end
      pv = neg ? 64'd0 - pm : pm;
      pv_neg = pv[63];
      wmag = pv_neg ? 64'd0 - pv : pv;
      limit = pv_neg ? NEG_LIMIT : POS_LIMIT;
      prod = (128'(wmag) * 128'(p.weight)) >> FRAC_BITS;
      if (prod > 128'(limit)) begin
         prod = 128'(limit);
         sat = 1;
      end
      term = pv_neg ? 64'd0 - prod[63:0] : prod[63:0];
      base = p.restart ? 64'd0 : sum_state;
      sum = base + term;
      if (base[63] == term[63] && sum[63] != base[63]) begin
         sum = base[63] ? NEG_LIMIT : POS_LIMIT;
         sat = 1;
      end
      sum_state = sum;
      r.equiv = vm[35:0];
      r.point_value = pv;
      r.running_sum = sum;
      r.saturated = sat;
      return r;
   endfunction

   // driver
   always @(posedge clock) begin
      bit      took, offer;
      int      idle_pct;
      point_type p;
      took = 0;
      if (!reset && req_tvalid && req_tready) begin
         expected_results.push_back(eval_point(pending_points.pop_front()));
         accepted++;
         took = 1;
      end
      idle_pct = idle_mode == 0 ? 8 : idle_mode == 1 ? 65 : 0;
      offer = !reset && pending_points.size() > 0 && $urandom_range(99) >= idle_pct;
      // keep valid up on a beat that was offered but not taken
      if (req_tvalid && !took && !reset) offer = 1;
      if (offer) begin
         p = pending_points[0];
         req_tdata <= {p.weight, p.stress[5], p.stress[4], p.stress[3], p.stress[2],
                       p.stress[1], p.stress[0]};
         req_tuser <= p.restart;
      end
      req_tvalid <= offer;
   end

   // monitor
   int  hold_left = 0;
   bit  held = 0;
   always @(posedge clock) begin
      result_type exp_r;
      int idle_pct;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected beat, actual %h/%b", $time, rsp_tdata, rsp_tuser);
            fails++;
         end else begin
            exp_r = expected_results.pop_front();
            if (rsp_tdata[35:0] !== exp_r.equiv) begin
               $display("%0t: equivalent_stress expected %h actual %h", $time,
                        exp_r.equiv, rsp_tdata[35:0]);
               fails++;
            end
            if (rsp_tdata[99:36] !== exp_r.point_value) begin
               $display("%0t: point_value expected %h actual %h", $time,
                        exp_r.point_value, rsp_tdata[99:36]);
               fails++;
            end
            if (rsp_tdata[163:100] !== exp_r.running_sum) begin
               $display("%0t: running_sum expected %h actual %h", $time,
                        exp_r.running_sum, rsp_tdata[163:100]);
               fails++;
            end
            if (rsp_tuser[0] !== exp_r.saturated) begin
               $display("%0t: saturated expected %b actual %b", $time,
                        exp_r.saturated, rsp_tuser[0]);
               fails++;
            end
         end
      end
      // one long hold-off so the queue fills and the input stalls
      if (!held && accepted >= 700 && pending_points.size() > 4) begin
         held = 1;
         hold_left = 3000;
      end
      if (hold_left > 0) hold_left--;
      idle_pct = idle_mode == 0 ? 65 : idle_mode == 1 ? 8 : 0;
      rsp_tready <= !reset && hold_left == 0 && $urandom_range(99) >= idle_pct;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic wait_idle();
      while (pending_points.size() > 0 || expected_results.size() > 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [31:0] value);
      @(posedge clock);
      csr_wen <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      case (idx)
         CSR_LAYOUT:   cfg_layout = value[1:0];
         CSR_REF:      cfg_ref = value;
         CSR_EXPONENT: cfg_exp = value[4:0];
         default: ;
      endcase
      @(posedge clock);
      csr_wen <= 1'b0;
   endtask

   task automatic set_config(logic [1:0] layout, logic [31:0] refv, logic [4:0] e);
      wait_idle();
      csr_write(CSR_LAYOUT, 32'(layout));
      csr_write(CSR_REF, refv);
      csr_write(CSR_EXPONENT, 32'(e));
   endtask

   function automatic logic [31:0] rand_stress(int kind);
      case (kind)
         0: return $urandom;
         1: return 32'($signed($urandom_range(262144)) - 131072);
         2: return 32'($signed($urandom_range(8192)) - 4096);
         3: return 32'h0;
         4: return 32'h7FFFFFFF;
         default: return 32'h80000000;
      endcase
   endfunction

   task automatic add_point(logic [31:0] s0, logic [31:0] s1, logic [31:0] s2,
                            logic [31:0] s3, logic [31:0] s4, logic [31:0] s5,
                            logic [31:0] w, logic rs);
      point_type p;
      p.stress = {s5, s4, s3, s2, s1, s0};
      p.weight = w;
      p.restart = rs;
      pending_points.push_back(p);
   endtask

   task automatic add_random(int count);
      int scale, k;
      logic [31:0] s[6];
      logic [31:0] w;
      for (int n = 0; n < count; n++) begin
         if (accepted + pending_points.size() >= 666) idle_mode = 2;
         else if (accepted + pending_points.size() >= 333) idle_mode = 1;
         // mostly one scale per point so the stress lands near the reference
         scale = $urandom_range(9);
         for (int i = 0; i < 6; i++) begin
            k = scale < 2 ? 0 : scale < 5 ? 1 : scale < 8 ? 2 : $urandom_range(5);
            s[i] = rand_stress(k);
         end
         case ($urandom_range(3))
            0: w = $urandom;
            1: w = 32'd65536;
            default: w = $urandom_range(262144);
         endcase
         add_point(s[0], s[1], s[2], s[3], s[4], s[5], w, $urandom_range(9) == 0);
      end
   endtask

   initial begin
      logic [31:0] refv;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // directed, reset configuration
      add_point('0, '0, '0, '0, '0, '0, 32'd65536, 1'b1);
      add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
                32'h80000000, 32'hFFFFFFFF, 1'b0);
      add_point(32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000, 32'h80000000,
                32'h80000000, 32'hFFFFFFFF, 1'b0);
      add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, '0, '0, '0, '0, 1'b0);
      add_point(32'd131072, '0, '0, '0, '0, '0, 32'd65536, 1'b1);
      add_point(32'h00010000, 32'hFFFF0000, 32'd0, 32'd32768, 32'd1, 32'hFFFFFFFF,
                32'd98304, 1'b0);
      set_config(LAYOUT_PLANE_STRESS, 32'd0, 5'd0);
      add_point(32'd5, 32'd3, 32'd7, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF, 32'd65536, 1'b0);
      add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF, '0, '0, '0, 32'hFFFFFFFF, 1'b1);
      set_config(LAYOUT_PLANE_STRAIN, 32'hFFFFFFFF, 5'd31);
      add_point(32'h7FFFFFFF, 32'h80000000, 32'h0, 32'h80000000, 32'd9, 32'd9,
                32'hFFFFFFFF, 1'b0);
      add_point(32'd65536, 32'd0, 32'd0, 32'd0, '0, '0, 32'd65536, 1'b0);
      set_config(2'd3, 32'd1, 5'd16);
      add_point(32'd1, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd65536, 1'b1);
      add_point(32'h7FFFFFFF, 32'h80000000, 32'd0, 32'h80000000, 32'h80000000,
                32'h80000000, 32'hFFFFFFFF, 1'b0);
      add_point(32'h80000000, 32'h7FFFFFFF, 32'd0, 32'h7FFFFFFF, 32'h7FFFFFFF,
                32'h7FFFFFFF, 32'hFFFFFFFF, 1'b0);
      set_config(LAYOUT_SOLID, 32'd65536, 5'd3);
      // below reference, odd exponent gives a negative value
      add_point(32'd16384, '0, '0, '0, '0, '0, 32'd65536, 1'b1);
      add_point(32'd16384, '0, '0, '0, '0, '0, 32'hFFFFFFFF, 1'b0);

      // random phases
      for (int ph = 0; ph < 10; ph++) begin
         case ($urandom_range(3))
            0: refv = $urandom;
            1: refv = $urandom_range(32'h00200000, 32'h00008000);
            2: refv = $urandom_range(32'h00040000, 32'h00000100);
            default: refv = ph == 9 ? 32'hFFFFFFFF : 32'd65536;
         endcase
         set_config(2'($urandom_range(3)), refv,
                    $urandom_range(3) == 0 ? 5'($urandom_range(31)) :
                                             5'($urandom_range(4, 1)));
         add_random(100);
      end

      wait_idle();
      repeat (400) @(posedge clock);
      if (fails == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
